// File: rtl/bst_pkg.sv
`default_nettype none

package bst_pkg;

    // field widths of one item
    localparam int OPCODE_W   = 2;
    localparam int KEY_W      = 32;
    localparam int POSITION_W = 6;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             cmp_en;
        logic [KEY_W-1:0] key;
        logic             wr_en;
        logic [KEY_W-1:0] wr_data;
    } bst_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bst_cell.sv
`default_nettype none

module bst_cell #(
    parameter int INDEX    = 0,
    parameter int IW       = 6,
    parameter int CW       = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bst_pkg::bst_ctrl_t        ctrl,
    input  wire logic [CW-1:0]             count,
    input  wire logic [IW-1:0]             wr_idx,
    output logic [bst_pkg::KEY_W-1:0]      last_value,
    output logic                           match
);
    import bst_pkg::*;

    localparam logic [CW-1:0] MY_IDX  = CW'(INDEX);
    localparam logic [CW-1:0] MY_NEXT = CW'(INDEX + 1);
    localparam logic [IW-1:0] MY_SLOT = IW'(INDEX);

    logic [KEY_W-1:0] value_reg;
    logic             match_reg;
    logic             held;

    // slot is held while below the fill count
    assign held = (count > MY_IDX);

    // stored key, written by append or by compaction
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && (wr_idx == MY_SLOT))
        begin
            value_reg <= ctrl.wr_data;
        end
    end

    // compare result for the item in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= held && (value_reg == ctrl.key);
        end
    end

    // the last held cell offers its key for swap-remove
    assign last_value = (count == MY_NEXT) ? value_reg : '0;
    assign match      = match_reg;

endmodule

`default_nettype wire

// File: rtl/bounded_set_table.sv
// an item is compared in parallel in the cell row, then decided and written
//   back (append or swap-remove) in the update state; its result is registered
//   on commit, which waits while an untaken result is held; no new item is taken until then
// a finished result waits in the output register while the next item runs
// reset: fill count cleared to zero, stored keys undefined until written
`default_nettype none

module bounded_set_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // opcode[1:0], key[33:2], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // found[0], position[6:1], count[13:7], status[15:14]
);
    import bst_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {S_IDLE, S_UPDATE} state_t;

    state_t                state_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [OPCODE_W-1:0]   op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;
    logic [15:0]           out_data_next;

    bst_ctrl_t             ctrl;
    logic [CAPACITY-1:0]   match_vec;
    logic [KEY_W-1:0]      cell_last [CAPACITY];
    logic [KEY_W-1:0]      last_val;
    logic [IW-1:0]         slot;
    logic [IW-1:0]         wr_idx;
    logic                  hit;
    logic                  full;
    logic                  commit;
    logic                  accept;
    logic [IW-1:0]         pos;
    logic [STATUS_W-1:0]   status;
    logic [31:0]           pos_wide;
    logic [31:0]           count_wide;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign commit        = (state_reg == S_UPDATE) && (!out_valid_reg || m_axis_tready);

    // row of cells, one stored key each
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bst_cell #(
            .INDEX    (i),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count_reg),
            .wr_idx     (wr_idx),
            .last_value (cell_last[i]),
            .match      (match_vec[i])
        );
    end

    // hit slot and last held key from the row; keys are unique so OR suffices
    always_comb
    begin
        slot     = '0;
        last_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                slot = slot | IW'(i);
            end
            last_val = last_val | cell_last[i];
        end
    end

    assign hit  = |match_vec;
    assign full = (count_reg >= CW'(CAPACITY));

    // decision and write-back for the item in flight
    always_comb
    begin
        count_next   = count_reg;
        pos          = hit ? slot : '0;
        status       = hit ? ST_DONE : ST_ABSENT;
        wr_idx       = slot;
        ctrl.cmp_en  = accept;
        ctrl.key     = s_axis_tdata[KEY_W+OPCODE_W-1:OPCODE_W];
        ctrl.wr_en   = 1'b0;
        ctrl.wr_data = last_val;
        unique case (op_reg)
            OP_ADD:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (hit)
                begin
                    status = ST_PRESENT;
                end
                else
                begin
                    pos          = count_reg[IW-1:0];
                    wr_idx       = count_reg[IW-1:0];
                    ctrl.wr_en   = commit;
                    ctrl.wr_data = key_reg;
                    count_next   = count_reg + CW'(1);
                    status       = ST_DONE;
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    ctrl.wr_en = commit;
                    count_next = count_reg - CW'(1);
                    status     = ST_DONE;
                end
            end
            default:
            begin
                // lookup, and the unused code treated as one
            end
        endcase
        pos_wide      = 32'(pos);
        count_wide    = 32'(count_next);
        out_data_next = {status, count_wide[COUNT_W-1:0],
                         pos_wide[POSITION_W-1:0], hit};
    end

    // sequencer, fill count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_LOOKUP;
            key_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            // result taken and no new one arriving in its place
            if (m_axis_tvalid && m_axis_tready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= s_axis_tdata[OPCODE_W-1:0];
                        key_reg   <= s_axis_tdata[KEY_W+OPCODE_W-1:OPCODE_W];
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (commit)
                    begin
                        count_reg     <= count_next;
                        out_data_reg  <= out_data_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a key is never held twice
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // fill count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // fill count moves by at most one per commit
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(commit) &&
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1)))))
        else $error("fill count changed outside a commit");

    // an accepted item always moves to the update cycle
    a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_UPDATE))
        else $error("accepted item did not reach update");

    // a commit never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
